@@ design/qrs_pkg.sv @@
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Holds the result format and the status codes that the solver reports.
// ----------------------------------------------------------------------------
package qrs_pkg;

    // Width of each root on the result ports, 16 fraction bits included.
    localparam int ROOT_BITS = 34;

    typedef enum logic [2:0] {
        ST_NONE    = 3'd0,
        ST_LINEAR  = 3'd1,
        ST_DOUBLE  = 3'd2,
        ST_TWO     = 3'd3,
        ST_COMPLEX = 3'd4
    } status_t;

endpackage

@@ design/qrs_isqrt.sv @@
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit floor square root, one root bit per register stage, with a
// sideband that travels alongside each beat.
// ----------------------------------------------------------------------------
module qrs_isqrt #(
    parameter int RW     = 33,
    parameter int SIDE_W = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [2*RW-1:0]     rad,
    input  logic [SIDE_W-1:0]   side_in,
    output logic                out_valid,
    output logic [RW-1:0]       root,
    output logic [SIDE_W-1:0]   side_out
);

    logic [RW-1:0]     rem_reg  [RW];
    logic [RW-1:0]     root_reg [RW];
    logic [2*RW-1:0]   rad_reg  [RW];
    logic [SIDE_W-1:0] side_reg [RW];
    logic              valid_reg [RW];

    for (genvar i = 0; i < RW; i++) begin : g_stage
        logic [RW-1:0]     rem_cur;
        logic [RW-1:0]     root_cur;
        logic [2*RW-1:0]   rad_cur;
        logic [SIDE_W-1:0] side_cur;
        logic              valid_cur;
        logic [RW+1:0]     rem_sh;
        logic [RW+1:0]     trial;
        logic              ge;

        if (i == 0) begin : g_first
            assign rem_cur   = '0;
            assign root_cur  = '0;
            assign rad_cur   = rad;
            assign side_cur  = side_in;
            assign valid_cur = in_valid;
        end
        else begin : g_rest
            assign rem_cur   = rem_reg[i-1];
            assign root_cur  = root_reg[i-1];
            assign rad_cur   = rad_reg[i-1];
            assign side_cur  = side_reg[i-1];
            assign valid_cur = valid_reg[i-1];
        end

        // Bring down the next two radicand bits and try appending a one.
        assign rem_sh = {rem_cur, rad_cur[2*RW-1 -: 2]};
        assign trial  = {root_cur, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= valid_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= ge ? RW'(rem_sh - trial) : RW'(rem_sh);
                root_reg[i] <= {root_cur[RW-2:0], ge};
                rad_reg[i]  <= rad_cur << 2;
                side_reg[i] <= side_cur;
            end
        end
    end

    assign out_valid = valid_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign side_out  = side_reg[RW-1];

endmodule

@@ design/qrs_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined dual-lane unsigned divider
// Restoring division of two dividends by one shared divisor, one quotient
// bit per register stage, with a sideband that travels with each beat.
// ----------------------------------------------------------------------------
module qrs_div #(
    parameter int NW     = 34,
    parameter int MW     = 17,
    parameter int SIDE_W = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [NW-1:0]       num1,
    input  logic [NW-1:0]       num2,
    input  logic [MW-1:0]       den,
    input  logic [SIDE_W-1:0]   side_in,
    output logic                out_valid,
    output logic [NW-1:0]       quot1,
    output logic [NW-1:0]       quot2,
    output logic [SIDE_W-1:0]   side_out
);

    logic [MW-1:0]     rem1_reg  [NW];
    logic [MW-1:0]     rem2_reg  [NW];
    logic [NW-1:0]     sh1_reg   [NW];
    logic [NW-1:0]     sh2_reg   [NW];
    logic [MW-1:0]     den_reg   [NW];
    logic [SIDE_W-1:0] side_reg  [NW];
    logic              valid_reg [NW];

    for (genvar i = 0; i < NW; i++) begin : g_stage
        logic [MW-1:0]     rem1_cur;
        logic [MW-1:0]     rem2_cur;
        logic [NW-1:0]     sh1_cur;
        logic [NW-1:0]     sh2_cur;
        logic [MW-1:0]     den_cur;
        logic [SIDE_W-1:0] side_cur;
        logic              valid_cur;
        logic [MW:0]       rem1_sh;
        logic [MW:0]       rem2_sh;
        logic              ge1;
        logic              ge2;

        if (i == 0) begin : g_first
            assign rem1_cur  = '0;
            assign rem2_cur  = '0;
            assign sh1_cur   = num1;
            assign sh2_cur   = num2;
            assign den_cur   = den;
            assign side_cur  = side_in;
            assign valid_cur = in_valid;
        end
        else begin : g_rest
            assign rem1_cur  = rem1_reg[i-1];
            assign rem2_cur  = rem2_reg[i-1];
            assign sh1_cur   = sh1_reg[i-1];
            assign sh2_cur   = sh2_reg[i-1];
            assign den_cur   = den_reg[i-1];
            assign side_cur  = side_reg[i-1];
            assign valid_cur = valid_reg[i-1];
        end

        // The dividend shifts out at the top while quotient bits enter below.
        assign rem1_sh = {rem1_cur, sh1_cur[NW-1]};
        assign rem2_sh = {rem2_cur, sh2_cur[NW-1]};
        assign ge1     = (rem1_sh >= {1'b0, den_cur});
        assign ge2     = (rem2_sh >= {1'b0, den_cur});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= valid_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem1_reg[i] <= ge1 ? MW'(rem1_sh - {1'b0, den_cur}) : MW'(rem1_sh);
                rem2_reg[i] <= ge2 ? MW'(rem2_sh - {1'b0, den_cur}) : MW'(rem2_sh);
                sh1_reg[i]  <= {sh1_cur[NW-2:0], ge1};
                sh2_reg[i]  <= {sh2_cur[NW-2:0], ge2};
                den_reg[i]  <= den_cur;
                side_reg[i] <= side_cur;
            end
        end
    end

    assign out_valid = valid_reg[NW-1];
    assign quot1     = sh1_reg[NW-1];
    assign quot2     = sh2_reg[NW-1];
    assign side_out  = side_reg[NW-1];

endmodule

@@ design/quadratic_root_solver.sv @@
// Pipeline: coefficient product stage, discriminant stage, bit-per-stage square
// root, numerator stage, bit-per-stage divider and output register.
// Throughput: one beat per cycle; the whole pipeline holds while a finished
// result is stalled at the output.
// Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// Quadratic root solver
// Real roots of a*x^2 + b*x + c in saturated fixed point, with a status code.
// ----------------------------------------------------------------------------
module quadratic_root_solver #(
    parameter int COEF_BITS = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [COEF_BITS-1:0]           coef_a,
    input  logic signed [COEF_BITS-1:0]           coef_b,
    input  logic signed [COEF_BITS-1:0]           coef_c,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [qrs_pkg::ROOT_BITS-1:0]  first_root,
    output logic signed [qrs_pkg::ROOT_BITS-1:0]  second_root,
    output logic [2:0]                            root_status
);

    localparam int CB    = COEF_BITS;
    localparam int F     = FRAC_BITS;
    localparam int RB    = qrs_pkg::ROOT_BITS;
    localparam int PW    = 2 * CB;
    localparam int DW2   = 2 * CB + 1;
    localparam int RW    = CB + F + 1;
    localparam int RADW  = 2 * RW;
    localparam int NBW   = CB + F + 1;
    localparam int DENW  = CB + 2;
    localparam int NW    = CB + F + 2;
    localparam int MW    = CB + 1;
    localparam int SW    = ((NW + 1 > RB) ? NW + 1 : RB) + 1;
    localparam int SQ_SIDE  = 3 + NBW + DENW;
    localparam int DIV_SIDE = 5;
    localparam logic signed [SW-1:0] RMAX = SW'((64'sd1 <<< (RB - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] RMIN = SW'(-(64'sd1 <<< (RB - 1)));

    logic en;

    // Stage 1: coefficient magnitudes squared and multiplied.
    logic [CB-1:0]          a_mag;
    logic [CB-1:0]          b_mag;
    logic [CB-1:0]          c_mag;
    logic                   v1_reg;
    logic signed [CB-1:0]   a_reg;
    logic signed [CB-1:0]   b_reg;
    logic signed [CB-1:0]   c_reg;
    logic [PW-1:0]          bsq_reg;
    logic [PW-1:0]          ac_reg;

    // Stage 2: discriminant and classification.
    logic [DW2-1:0]         q_ext;
    logic [DW2-1:0]         p4;
    logic [DW2-1:0]         d_val;
    logic                   same_sign;
    logic                   d_pos;
    logic                   d_zero;
    qrs_pkg::status_t       status_next;
    logic signed [NBW-1:0]  b_x;
    logic signed [NBW-1:0]  c_x;
    logic signed [NBW-1:0]  nb_next;
    logic signed [DENW-1:0] den_next;
    logic [RADW-1:0]        rad_next;
    logic                   v2_reg;
    logic [RADW-1:0]        rad_reg;
    logic [SQ_SIDE-1:0]     sq_side_reg;

    // Square root outputs.
    logic                   sq_valid;
    logic [RW-1:0]          sq_root;
    logic [SQ_SIDE-1:0]     sq_side;

    // Numerator stage.
    logic [2:0]             sq_status;
    logic signed [NBW-1:0]  sq_nb;
    logic signed [DENW-1:0] sq_den;
    logic signed [NW:0]     n1;
    logic signed [NW:0]     n2;
    logic signed [NW:0]     s_ext;
    logic signed [NW:0]     nb_ext;
    logic signed [DENW-1:0] den_abs;
    logic                   vp_reg;
    logic [NW-1:0]          n1m_reg;
    logic [NW-1:0]          n2m_reg;
    logic [MW-1:0]          dm_reg;
    logic [DIV_SIDE-1:0]    dv_side_reg;

    // Divider outputs and final stage.
    logic                   dv_valid;
    logic [NW-1:0]          q1;
    logic [NW-1:0]          q2;
    logic [DIV_SIDE-1:0]    dv_side;
    qrs_pkg::status_t       fin_status;
    logic signed [NW:0]     q1_s;
    logic signed [NW:0]     q2_s;
    logic signed [SW-1:0]   q1_x;
    logic signed [SW-1:0]   q2_x;
    logic signed [RB-1:0]   r1_sat;
    logic signed [RB-1:0]   r2_sat;
    logic                   out_valid_reg;
    logic signed [RB-1:0]   first_root_reg;
    logic signed [RB-1:0]   second_root_reg;
    logic [2:0]             root_status_reg;

    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    assign a_mag = coef_a[CB-1] ? (~coef_a + 1'b1) : coef_a;
    assign b_mag = coef_b[CB-1] ? (~coef_b + 1'b1) : coef_b;
    assign c_mag = coef_c[CB-1] ? (~coef_c + 1'b1) : coef_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            vp_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            vp_reg        <= sq_valid;
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg   <= coef_a;
            b_reg   <= coef_b;
            c_reg   <= coef_c;
            bsq_reg <= b_mag * b_mag;
            ac_reg  <= a_mag * c_mag;
        end
    end

    assign q_ext     = DW2'(bsq_reg);
    assign p4        = DW2'({ac_reg, 2'b00});
    assign same_sign = (c_reg != '0) && (a_reg[CB-1] == c_reg[CB-1]);

    always_comb
    begin
        if (!same_sign)
        begin
            d_val  = q_ext + p4;
            d_pos  = (d_val != '0);
            d_zero = (d_val == '0);
        end
        else
        begin
            d_val  = q_ext - p4;
            d_pos  = (q_ext > p4);
            d_zero = (q_ext == p4);
        end
    end

    always_comb
    begin
        if (a_reg == '0)
        begin
            status_next = (b_reg == '0) ? qrs_pkg::ST_NONE : qrs_pkg::ST_LINEAR;
        end
        else if (d_pos)
        begin
            status_next = qrs_pkg::ST_TWO;
        end
        else if (d_zero)
        begin
            status_next = qrs_pkg::ST_DOUBLE;
        end
        else
        begin
            status_next = qrs_pkg::ST_COMPLEX;
        end
    end

    assign b_x = {{(F + 1){b_reg[CB-1]}}, b_reg};
    assign c_x = {{(F + 1){c_reg[CB-1]}}, c_reg};

    // A linear equation divides -c by b; otherwise -b is divided by 2a.
    assign nb_next  = (a_reg == '0) ? -(c_x <<< F) : -(b_x <<< F);
    assign den_next = (a_reg == '0) ? {{2{b_reg[CB-1]}}, b_reg}
                                    : {a_reg[CB-1], a_reg, 1'b0};
    // A zero radicand makes the root zero, so a double root needs no special path.
    assign rad_next = (status_next == qrs_pkg::ST_TWO) ? (RADW'(d_val) << (2 * F)) : '0;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg     <= rad_next;
            sq_side_reg <= {status_next, nb_next, den_next};
        end
    end

    qrs_isqrt #(
        .RW     (RW),
        .SIDE_W (SQ_SIDE)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2_reg),
        .rad       (rad_reg),
        .side_in   (sq_side_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    assign sq_status = sq_side[SQ_SIDE-1 -: 3];
    assign sq_nb     = sq_side[NBW+DENW-1 -: NBW];
    assign sq_den    = sq_side[DENW-1:0];
    assign s_ext     = {2'b00, sq_root};
    assign nb_ext    = {{2{sq_nb[NBW-1]}}, sq_nb};
    assign n1        = nb_ext + s_ext;
    assign n2        = nb_ext - s_ext;
    assign den_abs   = sq_den[DENW-1] ? -sq_den : sq_den;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1m_reg     <= n1[NW] ? NW'(-n1) : NW'(n1);
            n2m_reg     <= n2[NW] ? NW'(-n2) : NW'(n2);
            dm_reg      <= MW'(den_abs);
            dv_side_reg <= {sq_status, n1[NW] ^ sq_den[DENW-1], n2[NW] ^ sq_den[DENW-1]};
        end
    end

    qrs_div #(
        .NW     (NW),
        .MW     (MW),
        .SIDE_W (DIV_SIDE)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vp_reg),
        .num1      (n1m_reg),
        .num2      (n2m_reg),
        .den       (dm_reg),
        .side_in   (dv_side_reg),
        .out_valid (dv_valid),
        .quot1     (q1),
        .quot2     (q2),
        .side_out  (dv_side)
    );

    assign fin_status = qrs_pkg::status_t'(dv_side[4:2]);
    assign q1_s = dv_side[1] ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
    assign q2_s = dv_side[0] ? -$signed({1'b0, q2}) : $signed({1'b0, q2});
    assign q1_x = {{(SW - NW - 1){q1_s[NW]}}, q1_s};
    assign q2_x = {{(SW - NW - 1){q2_s[NW]}}, q2_s};

    always_comb
    begin
        if (q1_x > RMAX)
        begin
            r1_sat = RB'(RMAX);
        end
        else if (q1_x < RMIN)
        begin
            r1_sat = RB'(RMIN);
        end
        else
        begin
            r1_sat = RB'(q1_x);
        end
        if (q2_x > RMAX)
        begin
            r2_sat = RB'(RMAX);
        end
        else if (q2_x < RMIN)
        begin
            r2_sat = RB'(RMIN);
        end
        else
        begin
            r2_sat = RB'(q2_x);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            root_status_reg <= fin_status;
            unique case (fin_status)
                qrs_pkg::ST_LINEAR, qrs_pkg::ST_DOUBLE:
                begin
                    first_root_reg  <= r1_sat;
                    second_root_reg <= '0;
                end
                qrs_pkg::ST_TWO:
                begin
                    first_root_reg  <= r1_sat;
                    second_root_reg <= r2_sat;
                end
                default:
                begin
                    first_root_reg  <= '0;
                    second_root_reg <= '0;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign first_root  = first_root_reg;
    assign second_root = second_root_reg;
    assign root_status = root_status_reg;

endmodule
